/* rtl/core/vepq_pkg.sv */
// ----------------------------------------------------------------------------
// vepq_pkg: shared types and constants of the voice-end pending queue
// Sizes, op codes and the control/status bundles between the top level,
// the pending queue and the playing bitmap.
// ----------------------------------------------------------------------------
package vepq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int NUM_HANDLES = 64;

  localparam int HANDLE_W = 6;
  localparam int OP_W     = 2;
  localparam int PCOUNT_W = 4;
  localparam int BITMAP_W = 64;
  localparam int IDX_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_START  = 2'd0;
  localparam logic [OP_W-1:0] OP_RECORD = 2'd1;
  localparam logic [OP_W-1:0] OP_APPLY  = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd3;

  // Queue control from the sequencer.
  typedef struct packed {
    logic                push;      // append handle at the tail
    logic                walk;      // process the entry read last cycle
    logic                start_op;  // walk compacts (1) or drains (0)
    logic [HANDLE_W-1:0] handle;
  } q_ctl_t;

  // Queue status back to the sequencer.
  typedef struct packed {
    logic [CNT_W-1:0]    count;
    logic                full;
    logic                empty;
    logic                last;      // entry under walk is the final one
    logic [HANDLE_W-1:0] rd_data;   // entry under walk
  } q_sts_t;

  // Bitmap control.
  typedef struct packed {
    logic                set;
    logic [HANDLE_W-1:0] set_h;
    logic                clr;
    logic [HANDLE_W-1:0] clr_h;
    logic [HANDLE_W-1:0] rd_h;
  } bm_ctl_t;

endpackage

/* rtl/core/voice_end_pending_queue.sv */
// Timing: query, record, apply with an empty queue and a start with nothing to compact
// go from the input transfer straight to the result state; a start or apply over pending
// entries first walks them one per cycle, then loads the registered result.
// Throughput: one item at a time (accept, walk, load result); a held result keeps the
// result register busy and delays the return to idle.
// Reset clears the bitmap, the pending count and the handshake state, not the queue memory.
// ----------------------------------------------------------------------------
// voice_end_pending_queue: top level
// Sequencer over the pending queue walk unit and the playing bitmap, with a
// registered result.
// ----------------------------------------------------------------------------
module voice_end_pending_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [vepq_pkg::OP_W-1:0]     op,
  input  logic [vepq_pkg::HANDLE_W-1:0] handle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          playing,
  output logic [vepq_pkg::PCOUNT_W-1:0] queue_level,
  output logic                          dropped
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                        state;
  state_t                        state_next;
  logic [vepq_pkg::OP_W-1:0]     op_r;
  logic [vepq_pkg::HANDLE_W-1:0] handle_r;
  logic                          hvalid_r;
  logic                          dropped_r;
  logic                          dropped_next;
  logic                          in_xfer;
  logic                          hvalid;
  logic                          load_out;
  logic                          rd_bit;
  logic [31:0]                   count_ext;
  vepq_pkg::q_ctl_t              q_ctl;
  vepq_pkg::q_sts_t              q_sts;
  vepq_pkg::bm_ctl_t             bm_ctl;

  assign in_ready  = (state == S_IDLE) && !rst;
  assign in_xfer   = in_valid && in_ready;
  assign hvalid    = ({1'b0, handle} < (vepq_pkg::HANDLE_W + 1)'(vepq_pkg::NUM_HANDLES));
  assign load_out  = (state == S_DONE) && (!out_valid || out_ready);
  assign count_ext = 32'(q_sts.count);

  always_comb begin
    state_next      = state;
    dropped_next    = dropped_r;
    q_ctl.push      = 1'b0;
    q_ctl.walk      = 1'b0;
    q_ctl.start_op  = (op_r == vepq_pkg::OP_START);
    q_ctl.handle    = in_xfer ? handle : handle_r;
    bm_ctl.set      = 1'b0;
    bm_ctl.set_h    = handle;
    bm_ctl.clr      = 1'b0;
    bm_ctl.clr_h    = q_sts.rd_data;
    bm_ctl.rd_h     = handle_r;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          dropped_next = 1'b0;
          state_next   = S_DONE;
          case (op)
            vepq_pkg::OP_START: begin
              bm_ctl.set = hvalid;
              if (hvalid && !q_sts.empty) begin
                state_next = S_WALK;
              end
            end
            vepq_pkg::OP_RECORD: begin
              q_ctl.push   = hvalid && !q_sts.full;
              dropped_next = hvalid && q_sts.full;
            end
            vepq_pkg::OP_APPLY: begin
              if (!q_sts.empty) begin
                state_next = S_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        q_ctl.walk = 1'b1;
        bm_ctl.clr = (op_r == vepq_pkg::OP_APPLY);
        if (q_sts.last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dropped_r <= dropped_next;
    if (in_xfer) begin
      op_r     <= op;
      handle_r <= handle;
      hvalid_r <= hvalid;
    end
    if (load_out) begin
      playing     <= hvalid_r && rd_bit;
      queue_level <= count_ext[vepq_pkg::PCOUNT_W-1:0];
      dropped     <= dropped_r;
    end
  end

  vepq_queue u_queue (
    .clk (clk),
    .rst (rst),
    .ctl (q_ctl),
    .sts (q_sts)
  );

  vepq_bitmap u_bitmap (
    .clk    (clk),
    .rst    (rst),
    .ctl    (bm_ctl),
    .rd_bit (rd_bit)
  );

endmodule

/* rtl/core/vepq_queue.sv */
// ----------------------------------------------------------------------------
// vepq_queue: pending handle FIFO with a walk unit
// Stores pending handles in a small memory with a registered read port and
// walks it one entry per cycle, compacting out one handle or draining it.
// ----------------------------------------------------------------------------
module vepq_queue (
  input  logic            clk,
  input  logic            rst,
  input  vepq_pkg::q_ctl_t ctl,
  output vepq_pkg::q_sts_t sts
);

  logic [vepq_pkg::HANDLE_W-1:0] mem [vepq_pkg::QUEUE_DEPTH];

  logic [vepq_pkg::CNT_W-1:0]    count;
  logic [vepq_pkg::CNT_W-1:0]    count_next;
  logic [vepq_pkg::CNT_W-1:0]    kept;
  logic [vepq_pkg::CNT_W-1:0]    kept_next;
  logic [vepq_pkg::CNT_W-1:0]    proc_idx;
  logic [vepq_pkg::CNT_W-1:0]    proc_plus;
  logic [vepq_pkg::IDX_W-1:0]    rd_addr;
  logic [vepq_pkg::HANDLE_W-1:0] rd_data;
  logic                          keep;
  logic                          last;
  logic [31:0]                   count_ext;
  logic [31:0]                   kept_ext;

  assign proc_plus = proc_idx + vepq_pkg::CNT_W'(1);
  assign last      = (proc_plus == count);
  assign keep      = ctl.start_op && (rd_data != ctl.handle);
  assign kept_next = keep ? kept + vepq_pkg::CNT_W'(1) : kept;
  assign count_ext = 32'(count);
  assign kept_ext  = 32'(kept);

  // Read ahead one entry while walking; park on entry zero otherwise.
  assign rd_addr = ctl.walk ? vepq_pkg::IDX_W'(32'(proc_plus)) : '0;

  always_comb begin
    count_next = count;
    if (ctl.push) begin
      count_next = count + vepq_pkg::CNT_W'(1);
    end else if (ctl.walk && last) begin
      count_next = ctl.start_op ? kept_next : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      kept     <= '0;
      proc_idx <= '0;
    end else begin
      count <= count_next;
      if (ctl.walk) begin
        if (last) begin
          kept     <= '0;
          proc_idx <= '0;
        end else begin
          kept     <= kept_next;
          proc_idx <= proc_plus;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (ctl.push) begin
      mem[vepq_pkg::IDX_W'(count_ext)] <= ctl.handle;
    end else if (ctl.walk && keep) begin
      mem[vepq_pkg::IDX_W'(kept_ext)] <= rd_data;
    end
  end

  assign sts.count   = count;
  assign sts.full    = (count_ext >= 32'(vepq_pkg::QUEUE_DEPTH));
  assign sts.empty   = (count == '0);
  assign sts.last    = last;
  assign sts.rd_data = rd_data;

endmodule

/* rtl/core/vepq_bitmap.sv */
// ----------------------------------------------------------------------------
// vepq_bitmap: playing bitmap
// One bit per voice handle with a set port, a clear port and a bit read.
// ----------------------------------------------------------------------------
module vepq_bitmap (
  input  logic              clk,
  input  logic              rst,
  input  vepq_pkg::bm_ctl_t ctl,
  output logic              rd_bit
);

  logic [vepq_pkg::BITMAP_W-1:0] view_bits;
  logic [vepq_pkg::BITMAP_W-1:0] view_bits_next;

  always_comb begin
    view_bits_next = view_bits;
    if (ctl.set) begin
      view_bits_next[ctl.set_h] = 1'b1;
    end
    if (ctl.clr) begin
      view_bits_next[ctl.clr_h] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      view_bits <= '0;
    end else begin
      view_bits <= view_bits_next;
    end
  end

  assign rd_bit = view_bits[ctl.rd_h];

endmodule

/* rtl/core/vepq_checker.sv */
// ----------------------------------------------------------------------------
// vepq_checker: port-level checks of the voice-end pending queue
// Watches the top level's ports and flags protocol and result slips.
// ----------------------------------------------------------------------------
module vepq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [vepq_pkg::OP_W-1:0]     op,
  input logic [vepq_pkg::HANDLE_W-1:0] handle,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          playing,
  input logic [vepq_pkg::PCOUNT_W-1:0] queue_level,
  input logic                          dropped
);

  localparam logic [31:0] DEPTH = 32'(vepq_pkg::QUEUE_DEPTH);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(playing)
      && $stable(queue_level) && $stable(dropped))
    else $error("result changed while stalled");

  // One item at a time: no transfer right after a transfer.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // Pending count never exceeds the queue depth.
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (DEPTH > 32'd15) || (32'(queue_level) <= DEPTH))
    else $error("pending count above queue depth");

  // A drop only happens on a full queue.
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped |-> (queue_level == DEPTH[vepq_pkg::PCOUNT_W-1:0]))
    else $error("drop reported with room in the queue");

endmodule

bind voice_end_pending_queue vepq_checker u_vepq_checker (.*);
